@@ hdl/palette_pixel_compositor_assert.svh @@
// Assertion macros for the palette pixel compositor.
// Included by the top level; no other dependencies.
`ifndef PALETTE_PIXEL_COMPOSITOR_ASSERT_SVH
`define PALETTE_PIXEL_COMPOSITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define PPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppc assertion failed");
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppc assertion failed");
`else
`define PPC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/ppc_pkg.sv @@
// Shared types and constants for the palette pixel compositor.
// No dependencies.
`timescale 1ns / 1ps

package ppc_pkg;

	localparam int PALETTE_DEPTH    = 256;
	localparam int MAX_CANVAS_WIDTH = 1024;
	localparam int MAX_FRAME_HEIGHT = 1024;
	localparam int PAL_AW           = $clog2(PALETTE_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENCY_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_INDEX   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X            = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y            = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT        = 3'd6;

	localparam logic CMD_PAL_WRITE = 1'b0;
	localparam logic CMD_PIXEL     = 1'b1;

	localparam logic MODE_RGB565 = 1'b0;
	localparam logic MODE_RGB888 = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  color_index;
		logic [23:0] entry_color;
		logic [9:0]  row;
		logic [9:0]  col;
	} item_t;

	typedef struct packed {
		logic        write_enable;
		logic [19:0] pixel_address;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
	} result_t;

	typedef struct packed {
		logic        palette_mode;
		logic        transparency_enable;
		logic [7:0]  transparent_index;
		logic [9:0]  origin_x;
		logic [9:0]  origin_y;
		logic [10:0] pitch;
		logic [10:0] height;
	} cfg_t;

	typedef struct packed {
		logic        keep;
		logic        idx_ok;
		logic [10:0] dx;
		logic [10:0] dy;
	} clip_t;

endpackage

@@ hdl/palette_pixel_compositor.sv @@
// Top level of the palette pixel compositor.
// Depends on ppc_pkg, ppc_cfg_regs, ppc_palette_ram, ppc_clip_stage, ppc_out_stage
// and palette_pixel_compositor_assert.svh.
// Usage:
//   item channel (item_valid/item_stall/item): a beat with cmd 0 stores
//   entry_color at palette entry color_index; a beat with cmd 1 is a pixel.
//   result channel (result_valid/result_stall/result): exactly one beat per
//   item beat, in order. Palette writes, clipped and color-keyed pixels give
//   write_enable 0 with all other fields zero.
//   cfg port: cfg_we with cfg_index/cfg_data writes one register at the
//   clock edge; write only while no item is in flight.
//   Path: each item beat is registered in the first stage, then in the result register.
//   Throughput: one item per cycle while item_stall is low, set by the single palette read port
//   feeding a two-stage pipeline.
//   Receiver stall: the result register holds; the first stage still takes
//   one more beat if it is empty, then item_stall rises until the result is taken.
//   Reset: pipeline empties and registers take their reset values; palette
//   contents are undefined until written.
`timescale 1ns / 1ps

module palette_pixel_compositor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  ppc_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output ppc_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ppc_pkg::*;

	`include "palette_pixel_compositor_assert.svh"

	cfg_t        cfg;
	clip_t       clip_s1;
	logic        valid_s1;
	logic [23:0] entry_s1;
	logic        en1;
	logic        en2;
	logic        accept;
	logic        pal_we;

	assign en2        = !result_valid || !result_stall;
	assign en1        = !valid_s1 || en2;
	assign item_stall = !en1;
	assign accept     = item_valid && en1;
	assign pal_we     = accept && (item.cmd == CMD_PAL_WRITE) &&
		(9'(item.color_index) < 9'(PALETTE_DEPTH));

	ppc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppc_palette_ram u_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (item.color_index[PAL_AW-1:0]),
		.wdata (item.entry_color),
		.re    (en1),
		.raddr (item.color_index[PAL_AW-1:0]),
		.rdata (entry_s1)
	);

	ppc_clip_stage u_clip (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en1),
		.item_valid (item_valid),
		.item       (item),
		.cfg        (cfg),
		.valid_s1   (valid_s1),
		.clip_s1    (clip_s1)
	);

	ppc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en2),
		.valid_s1  (valid_s1),
		.clip_s1   (clip_s1),
		.entry     (entry_s1),
		.cfg       (cfg),
		.valid_s2  (result_valid),
		.result_s2 (result)
	);

	`PPC_ASSERT_SAME(a_full_stalls, clk, arst_n, valid_s1 && result_valid && result_stall, item_stall)
	`PPC_ASSERT_NEXT(a_write_no_pixel, clk, arst_n, accept && (item.cmd == CMD_PAL_WRITE), valid_s1 && !clip_s1.keep)
	`PPC_ASSERT_SAME(a_drop_zero, clk, arst_n, result_valid && !result.write_enable, (result.pixel_address == 20'd0) && (result.red == 8'd0) && (result.green == 8'd0) && (result.blue == 8'd0))

endmodule

@@ hdl/ppc_cfg_regs.sv @@
// Configuration registers with saturated geometry.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data,
	output ppc_pkg::cfg_t                  cfg
);
	import ppc_pkg::*;

	logic        mode_q;
	logic        te_q;
	logic [7:0]  ti_q;
	logic [9:0]  ox_q;
	logic [9:0]  oy_q;
	logic [10:0] width_q;
	logic [10:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RGB888;
			te_q     <= 1'b0;
			ti_q     <= 8'd0;
			ox_q     <= 10'd0;
			oy_q     <= 10'd0;
			width_q  <= 11'd1024;
			height_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PALETTE_MODE:        mode_q   <= cfg_data[0];
				CFG_TRANSPARENCY_ENABLE: te_q     <= cfg_data[0];
				CFG_TRANSPARENT_INDEX:   ti_q     <= cfg_data[7:0];
				CFG_ORIGIN_X:            ox_q     <= cfg_data[9:0];
				CFG_ORIGIN_Y:            oy_q     <= cfg_data[9:0];
				CFG_CANVAS_WIDTH:        width_q  <= cfg_data[10:0];
				CFG_FRAME_HEIGHT:        height_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.palette_mode        = mode_q;
		cfg.transparency_enable = te_q;
		cfg.transparent_index   = ti_q;
		cfg.origin_x            = ox_q;
		cfg.origin_y            = oy_q;
		cfg.pitch  = (int'(width_q) > MAX_CANVAS_WIDTH) ? 11'(MAX_CANVAS_WIDTH) : width_q;
		cfg.height = (int'(height_q) > MAX_FRAME_HEIGHT) ? 11'(MAX_FRAME_HEIGHT) : height_q;
	end

endmodule

@@ hdl/ppc_palette_ram.sv @@
// Palette memory: one write port, one registered read port.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_palette_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ppc_pkg::PAL_AW-1:0] waddr,
	input  logic [23:0]               wdata,
	input  logic                      re,
	input  logic [ppc_pkg::PAL_AW-1:0] raddr,
	output logic [23:0]               rdata
);
	import ppc_pkg::*;

	logic [23:0] mem [PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ hdl/ppc_clip_stage.sv @@
// First stage: frame origin offset, clipping and color key test.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_clip_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           item_valid,
	input  ppc_pkg::item_t item,
	input  ppc_pkg::cfg_t  cfg,
	output logic           valid_s1,
	output ppc_pkg::clip_t clip_s1
);
	import ppc_pkg::*;

	clip_t clip_d;
	logic  drop;

	always_comb begin
		clip_d.dx     = 11'(cfg.origin_x) + 11'(item.col);
		clip_d.dy     = 11'(cfg.origin_y) + 11'(item.row);
		clip_d.idx_ok = 9'(item.color_index) < 9'(PALETTE_DEPTH);
		drop = (clip_d.dy >= cfg.height) || (clip_d.dx >= cfg.pitch) ||
			(cfg.transparency_enable && (item.color_index == cfg.transparent_index));
		clip_d.keep = (item.cmd == CMD_PIXEL) && !drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			clip_s1 <= clip_d;
	end

endmodule

@@ hdl/ppc_out_stage.sv @@
// Second stage: pixel address, color expansion and result register.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

module ppc_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_s1,
	input  ppc_pkg::clip_t   clip_s1,
	input  logic [23:0]      entry,
	input  ppc_pkg::cfg_t    cfg,
	output logic             valid_s2,
	output ppc_pkg::result_t result_s2
);
	import ppc_pkg::*;

	result_t     res_d;
	logic [21:0] prod;
	logic [23:0] color;
	logic [4:0]  r5;
	logic [5:0]  g6;
	logic [4:0]  b5;

	always_comb begin
		prod  = 22'(clip_s1.dy) * 22'(cfg.pitch);
		color = clip_s1.idx_ok ? entry : 24'd0;
		r5    = color[15:11];
		g6    = color[10:5];
		b5    = color[4:0];
		res_d = '0;
		if (clip_s1.keep) begin
			res_d.write_enable  = 1'b1;
			res_d.pixel_address = prod[19:0] + 20'(clip_s1.dx);
			if (cfg.palette_mode == MODE_RGB565) begin
				res_d.red   = {r5, r5[4:2]};
				res_d.green = {g6, g6[5:4]};
				res_d.blue  = {b5, b5[4:2]};
			end else begin
				res_d.red   = color[23:16];
				res_d.green = color[15:8];
				res_d.blue  = color[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en)
			result_s2 <= res_d;
	end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for palette_pixel_compositor: palette writes and pixel beats
// against an in-bench predictor of clipping, color keying and RGB565/RGB888 expansion.
// Depends on ppc_pkg and the palette_pixel_compositor RTL only.
`timescale 1ns / 1ps

module testbench;
	import ppc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int NUM_PHASES     = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_PRINTS     = 30;

	class frame_write_scoreboard;
		logic [23:0]    palette_ram [PALETTE_DEPTH];
		bit             written [PALETTE_DEPTH];
		int             written_list [$];
		logic           palette_fmt = MODE_RGB888;
		logic           key_enable  = 1'b0;
		logic [7:0]     key_index   = 8'd0;
		logic [9:0]     org_x       = 10'd0;
		logic [9:0]     org_y       = 10'd0;
		logic [10:0]    canvas_cols = 11'd1024;
		logic [10:0]    frame_h     = 11'd1024;
		result_t        expected_writes [$];
		int             errors = 0;
		int             beats_seen = 0;
		int             pixels_written = 0;

		function int eff_pitch();
			return (canvas_cols > MAX_CANVAS_WIDTH) ? MAX_CANVAS_WIDTH : int'(canvas_cols);
		endfunction

		function int eff_height();
			return (frame_h > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : int'(frame_h);
		endfunction

		function int pick_written();
			return written_list[$urandom_range(written_list.size() - 1)];
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, int value);
			case (idx)
				CFG_PALETTE_MODE:        palette_fmt = value[0];
				CFG_TRANSPARENCY_ENABLE: key_enable  = value[0];
				CFG_TRANSPARENT_INDEX:   key_index   = value[7:0];
				CFG_ORIGIN_X:            org_x       = value[9:0];
				CFG_ORIGIN_Y:            org_y       = value[9:0];
				CFG_CANVAS_WIDTH:        canvas_cols = value[10:0];
				CFG_FRAME_HEIGHT:        frame_h     = value[10:0];
				default: ;
			endcase
		endfunction

		function result_t apply_beat(item_t beat);
			result_t     res;
			logic [11:0] dx;
			logic [11:0] dy;
			logic [23:0] entry;
			logic [4:0]  r5;
			logic [5:0]  g6;
			logic [4:0]  b5;
			logic [31:0] addr;
			res = '0;
			if (beat.cmd == CMD_PAL_WRITE) begin
				palette_ram[beat.color_index] = beat.entry_color;
				if (!written[beat.color_index]) begin
					written[beat.color_index] = 1'b1;
					written_list.push_back(int'(beat.color_index));
				end
				return res;
			end
			dx = 12'(org_x) + 12'(beat.col);
			dy = 12'(org_y) + 12'(beat.row);
			if (int'(dy) >= eff_height() || int'(dx) >= eff_pitch() ||
			    (key_enable && beat.color_index == key_index))
				return res;
			entry = palette_ram[beat.color_index];
			if (palette_fmt == MODE_RGB565) begin
				r5 = entry[15:11];
				g6 = entry[10:5];
				b5 = entry[4:0];
				res.red   = {r5, r5[4:2]};
				res.green = {g6, g6[5:4]};
				res.blue  = {b5, b5[4:2]};
			end else begin
				res.red   = entry[23:16];
				res.green = entry[15:8];
				res.blue  = entry[7:0];
			end
			addr = 32'(dy) * 32'(eff_pitch()) + 32'(dx);
			res.pixel_address = addr[19:0];
			res.write_enable  = 1'b1;
			return res;
		endfunction

		function void note_item(item_t beat);
			result_t res;
			res = apply_beat(beat);
			expected_writes.push_back(res);
			beats_seen++;
			if (res.write_enable)
				pixels_written++;
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("tb: mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_writes.size() == 0) begin
				report($sformatf("result beat %h with nothing pending", got));
				return;
			end
			want = expected_writes.pop_front();
			if (got.write_enable !== want.write_enable)
				report($sformatf("write_enable %b, want %b", got.write_enable,
					want.write_enable));
			if (got.pixel_address !== want.pixel_address)
				report($sformatf("pixel_address %h, want %h", got.pixel_address,
					want.pixel_address));
			if (got.blue !== want.blue)
				report($sformatf("blue %h, want %h", got.blue, want.blue));
			if (got.green !== want.green)
				report($sformatf("green %h, want %h", got.green, want.green));
			if (got.red !== want.red)
				report($sformatf("red %h, want %h", got.red, want.red));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	item_t                  item;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	frame_write_scoreboard sb = new();
	int send_idle_pct = 8;
	int recv_idle_pct = 81;
	int hold_left = 0;

	palette_pixel_compositor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : result_sink
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	initial begin : watchdog
		int quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic item_t make_beat(logic cmd, int idx, int color, int row, int col);
		item_t beat;
		beat.cmd         = cmd;
		beat.color_index = 8'(idx);
		beat.entry_color = 24'(color);
		beat.row         = 10'(row);
		beat.col         = 10'(col);
		return beat;
	endfunction

	// Mostly inside the window, else its last position, just past it or anywhere.
	function automatic logic [9:0] pick_coord(int lim, int off);
		int span;
		span = lim - off;
		if (span <= 0 || $urandom_range(7) == 0)
			return 10'($urandom_range(1023));
		case ($urandom_range(5))
			0: return 10'(span - 1);
			1: return 10'((span > 1023) ? 1023 : span);
			default: return 10'($urandom_range(span - 1));
		endcase
	endfunction

	function automatic item_t random_beat();
		item_t beat;
		beat.cmd         = ($urandom_range(3) == 0) ? CMD_PAL_WRITE : CMD_PIXEL;
		beat.color_index = 8'($urandom_range(255));
		beat.entry_color = 24'($urandom);
		beat.row         = 10'($urandom_range(1023));
		beat.col         = 10'($urandom_range(1023));
		if (beat.cmd == CMD_PIXEL) begin
			if (sb.key_enable && sb.written[sb.key_index] && $urandom_range(5) == 0)
				beat.color_index = sb.key_index;
			else
				beat.color_index = 8'(sb.pick_written());
			beat.col = pick_coord(sb.eff_pitch(), int'(sb.org_x));
			beat.row = pick_coord(sb.eff_height(), int'(sb.org_y));
		end
		return beat;
	endfunction

	task automatic drive_item(item_t beat);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(beat);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		sb.set_reg(idx, value);
	endtask

	task automatic apply_settings(logic mode, int key_en, int key_idx, int ox, int oy,
			int cw, int fh);
		write_reg(CFG_PALETTE_MODE, int'(mode));
		write_reg(CFG_TRANSPARENCY_ENABLE, key_en);
		write_reg(CFG_TRANSPARENT_INDEX, key_idx);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_CANVAS_WIDTH, cw);
		write_reg(CFG_FRAME_HEIGHT, fh);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int phase_beats [NUM_PHASES] = '{100, 150, 100, 80, 60, 60, 200, 200};
		int ph;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 81;
				recv_idle_pct = 8;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph > 0)
				wait_drained();
			case (ph)
				1: apply_settings(MODE_RGB565, 1, 5, 0, 0, 640, 480);
				2: apply_settings(MODE_RGB888, 1, 255, 1023, 1023, 2047, 2047);
				3: apply_settings(MODE_RGB565, 0, 128, 0, 0, 1, 1);
				4: apply_settings(MODE_RGB888, 1, 0, 3, 9, 0, 1024);
				5: apply_settings(MODE_RGB565, 0, 170, 500, 200, 1024, 0);
				6, 7: apply_settings(1'($urandom_range(1)), $urandom_range(1),
					sb.pick_written(), $urandom_range(300), $urandom_range(300),
					$urandom_range(1024, 1), $urandom_range(1024, 1));
				default: ;
			endcase

			if (ph == 0) begin
				drive_item(make_beat(CMD_PAL_WRITE, 0, 24'h000000, 0, 0));
				drive_item(make_beat(CMD_PAL_WRITE, 255, 24'hFFFFFF, 0, 0));
				drive_item(make_beat(CMD_PAL_WRITE, 5, 24'h123456, 0, 0));
				drive_item(make_beat(CMD_PAL_WRITE, 128, 24'hA5C3E7, 0, 0));
				drive_item(make_beat(CMD_PAL_WRITE, 170, 24'h5A5A5A, 0, 0));
				drive_item(make_beat(CMD_PAL_WRITE, 85, 24'hA5A5A5, 0, 0));
				drive_item(make_beat(CMD_PAL_WRITE, 7, 24'hFF00FF, 1023, 1023));
				drive_item(make_beat(CMD_PIXEL, 0, 0, 0, 0));
				drive_item(make_beat(CMD_PIXEL, 255, 24'hFFFFFF, 1023, 1023));
				drive_item(make_beat(CMD_PIXEL, 5, 0, 0, 1023));
				drive_item(make_beat(CMD_PIXEL, 128, 0, 1023, 0));
				drive_item(make_beat(CMD_PIXEL, 170, 0, 341, 682));
				drive_item(make_beat(CMD_PIXEL, 85, 0, 682, 341));
				drive_item(make_beat(CMD_PIXEL, 7, 0, 512, 511));
			end else if (ph == 1) begin
				drive_item(make_beat(CMD_PIXEL, 5, 0, 10, 10));
				drive_item(make_beat(CMD_PIXEL, 255, 0, 479, 639));
				drive_item(make_beat(CMD_PIXEL, 128, 0, 0, 640));
				drive_item(make_beat(CMD_PIXEL, 128, 0, 480, 0));
				drive_item(make_beat(CMD_PIXEL, 0, 0, 0, 0));
				drive_item(make_beat(CMD_PIXEL, 170, 0, 100, 200));
				drive_item(make_beat(CMD_PIXEL, 85, 0, 200, 100));
			end else if (ph == 6) begin
				hold_left = HOLD_CYCLES;
			end

			repeat (phase_beats[ph]) drive_item(random_beat());
		end

		wait_drained();
		$display("tb: %0d item beats over %0d register settings, %0d pixels written",
			sb.beats_seen, NUM_PHASES, sb.pixels_written);
		$display("tb: palette formats, clipping, color key and a long result hold-off");
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
